// File: sv/vhd_pkg.sv
`timescale 1ns / 1ps

package vhd_pkg;

	localparam int COORD_W   = 16;
	localparam int MAG_W     = COORD_W;
	localparam int HEAD_W    = 9;
	localparam int DEG_W     = 7;
	localparam int NUM_CELLS = DEG_W;
	localparam int TAB_W     = 49;
	localparam int TAB_DEPTH = 91;
	localparam int PROD_W    = MAG_W + TAB_W;
	localparam int FRAC_W    = 62;
	localparam int TAB_SHIFT = FRAC_W - (TAB_W - 1);

	localparam int LAST_DEG  = 89;
	localparam int RIGHT_DEG = 90;

	localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C234;

	localparam logic [HEAD_W-1:0] HEAD_0   = 9'd0;
	localparam logic [HEAD_W-1:0] HEAD_45  = 9'd45;
	localparam logic [HEAD_W-1:0] HEAD_90  = 9'd90;
	localparam logic [HEAD_W-1:0] HEAD_180 = 9'd180;
	localparam logic [HEAD_W-1:0] HEAD_270 = 9'd270;
	localparam logic [HEAD_W-1:0] HEAD_MAX = 9'd359;

	typedef logic [TAB_W-1:0] cos_tab_t [TAB_DEPTH];

	typedef struct packed {
		logic [MAG_W-1:0] mag_x;
		logic [MAG_W-1:0] mag_y;
		logic             neg_x;
		logic             neg_y;
		logic [DEG_W-1:0] t;
	} item_t;

	// Cosine of a whole number of degrees (0..89) in Q48 with one integer bit.
	// Horner form of the Taylor series, carried in Q62.
	function automatic logic [TAB_W-1:0] cos_deg(input int unsigned deg);
		logic [127:0] one;
		logic [127:0] x;
		logic [127:0] x2;
		logic [127:0] r;
		one = 128'd1 << FRAC_W;
		x   = (128'(PI_Q62) * 128'(deg)) / 180;
		x2  = (x * x) >> FRAC_W;
		r   = one;
		r   = one - ((x2 * r) >> FRAC_W) / 552;
		r   = one - ((x2 * r) >> FRAC_W) / 462;
		r   = one - ((x2 * r) >> FRAC_W) / 380;
		r   = one - ((x2 * r) >> FRAC_W) / 306;
		r   = one - ((x2 * r) >> FRAC_W) / 240;
		r   = one - ((x2 * r) >> FRAC_W) / 182;
		r   = one - ((x2 * r) >> FRAC_W) / 132;
		r   = one - ((x2 * r) >> FRAC_W) / 90;
		r   = one - ((x2 * r) >> FRAC_W) / 56;
		r   = one - ((x2 * r) >> FRAC_W) / 30;
		r   = one - ((x2 * r) >> FRAC_W) / 12;
		r   = one - ((x2 * r) >> FRAC_W) / 2;
		return TAB_W'(r >> TAB_SHIFT);
	endfunction

	// Entry 90 is only reached as the sine of zero degrees, which is never compared.
	function automatic cos_tab_t build_cos_tab();
		cos_tab_t tab;
		for (int i = 0; i < TAB_DEPTH; i++) begin
			tab[i] = (i < RIGHT_DEG) ? cos_deg(i) : '0;
		end
		return tab;
	endfunction

	localparam cos_tab_t COS_TAB = build_cos_tab();

endpackage

// File: sv/vhd_cell.sv
`timescale 1ns / 1ps

module vhd_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_vld,
	input  vhd_pkg::item_t              in_item,
	input  logic [vhd_pkg::DEG_W-1:0]   step,
	output logic                        out_vld,
	output vhd_pkg::item_t              out_item
);

	logic [vhd_pkg::DEG_W:0]   k_sum;
	logic                      k_ok;
	logic [vhd_pkg::DEG_W-1:0] idx;
	logic [vhd_pkg::TAB_W-1:0] cos_v;
	logic [vhd_pkg::TAB_W-1:0] sin_v;

	logic                       vld_s1;
	vhd_pkg::item_t             item_s1;
	logic [vhd_pkg::DEG_W-1:0]  k_s1;
	logic                       ok_s1;
	logic [vhd_pkg::PROD_W-1:0] px_s1;
	logic [vhd_pkg::PROD_W-1:0] py_s1;

	vhd_pkg::item_t             item_nx;

	logic                       vld_s2;
	vhd_pkg::item_t             item_s2;

	// Candidate degree for this step of the binary search.
	assign k_sum = {1'b0, in_item.t} + {1'b0, step};
	assign k_ok  = k_sum <= (vhd_pkg::DEG_W + 1)'(vhd_pkg::LAST_DEG);
	assign idx   = k_ok ? k_sum[vhd_pkg::DEG_W-1:0] : '0;
	assign cos_v = vhd_pkg::COS_TAB[idx];
	assign sin_v = vhd_pkg::COS_TAB[vhd_pkg::DEG_W'(vhd_pkg::RIGHT_DEG) - idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= in_item;
		k_s1    <= k_sum[vhd_pkg::DEG_W-1:0];
		ok_s1   <= k_ok;
		px_s1   <= vhd_pkg::PROD_W'(in_item.mag_x) * vhd_pkg::PROD_W'(cos_v);
		py_s1   <= vhd_pkg::PROD_W'(in_item.mag_y) * vhd_pkg::PROD_W'(sin_v);
	end

	// The angle reaches the candidate when |dx|*cos(k) >= |dy|*sin(k).
	always_comb begin
		item_nx = item_s1;
		if (ok_s1 && (px_s1 >= py_s1)) begin
			item_nx.t = k_s1;
		end
	end

	always_ff @(posedge clk) begin
		item_s2 <= item_nx;
	end

	assign out_vld  = vld_s2;
	assign out_item = item_s2;

endmodule

// File: sv/vector_heading_degrees.sv
`timescale 1ns / 1ps

// Heading of a signed displacement (dx, dy) in whole degrees, 0 to 359,
// counter-clockwise from +x, with the angle inside a quadrant truncated. An
// item is taken on any cycle with start high and busy low; busy is high in
// reset and in the cycle after reset ends. Every item comes out on heading
// with done high for one cycle, and a new item may be started every cycle
// while busy is low. The pipeline is the chain of seven binary-search
// cells, each two stages deep (a table lookup with two multiplications,
// then a compare), plus one input and one output stage.
// done cannot be held off, so the receiver must take every result.
module vector_heading_degrees (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [vhd_pkg::COORD_W-1:0] dx,
	input  logic signed [vhd_pkg::COORD_W-1:0] dy,
	output logic [vhd_pkg::HEAD_W-1:0]   heading,
	output logic                         done
);

	localparam int LATENCY = 2 + 2 * vhd_pkg::NUM_CELLS;

	logic                        busy_q;
	logic                        accept;
	logic                        vld_s1;
	vhd_pkg::item_t              item_s1;
	logic                        vld_c  [vhd_pkg::NUM_CELLS+1];
	vhd_pkg::item_t              item_c [vhd_pkg::NUM_CELLS+1];
	vhd_pkg::item_t              last;
	logic                        x_zero;
	logic                        y_zero;
	logic [vhd_pkg::HEAD_W-1:0]  t_ext;
	logic [vhd_pkg::HEAD_W-1:0]  head_d;
	logic                        vld_s2;
	logic [vhd_pkg::HEAD_W-1:0]  head_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy   = busy_q;
	assign accept = start & ~busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_c[vhd_pkg::NUM_CELLS];
		end
	end

	// The most negative input keeps its full magnitude as an unsigned value.
	always_ff @(posedge clk) begin
		item_s1.neg_x <= dx[vhd_pkg::COORD_W-1];
		item_s1.neg_y <= dy[vhd_pkg::COORD_W-1];
		item_s1.mag_x <= dx[vhd_pkg::COORD_W-1] ? vhd_pkg::MAG_W'(~dx + 1'b1)
		                                        : vhd_pkg::MAG_W'(dx);
		item_s1.mag_y <= dy[vhd_pkg::COORD_W-1] ? vhd_pkg::MAG_W'(~dy + 1'b1)
		                                        : vhd_pkg::MAG_W'(dy);
		item_s1.t     <= '0;
	end

	assign vld_c[0]  = vld_s1;
	assign item_c[0] = item_s1;

	for (genvar i = 0; i < vhd_pkg::NUM_CELLS; i++) begin : g_cell
		vhd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_vld   (vld_c[i]),
			.in_item  (item_c[i]),
			.step     (vhd_pkg::DEG_W'(1) << (vhd_pkg::NUM_CELLS - 1 - i)),
			.out_vld  (vld_c[i+1]),
			.out_item (item_c[i+1])
		);
	end

	assign last   = item_c[vhd_pkg::NUM_CELLS];
	assign x_zero = (last.mag_x == '0);
	assign y_zero = (last.mag_y == '0);
	assign t_ext  = vhd_pkg::HEAD_W'(last.t);

	always_comb begin
		if (x_zero && y_zero) begin
			head_d = vhd_pkg::HEAD_45;
		end else if (y_zero) begin
			head_d = last.neg_x ? vhd_pkg::HEAD_180 : vhd_pkg::HEAD_0;
		end else if (x_zero) begin
			head_d = last.neg_y ? vhd_pkg::HEAD_270 : vhd_pkg::HEAD_90;
		end else if (last.neg_x && !last.neg_y) begin
			head_d = vhd_pkg::HEAD_90 + t_ext;
		end else if (!last.neg_x && last.neg_y) begin
			head_d = vhd_pkg::HEAD_270 + t_ext;
		end else if (!last.neg_x && !last.neg_y) begin
			head_d = vhd_pkg::HEAD_90 - t_ext;
		end else begin
			head_d = vhd_pkg::HEAD_270 - t_ext;
		end
	end

	always_ff @(posedge clk) begin
		head_s2 <= head_d;
	end

	assign heading = head_s2;
	assign done    = vld_s2;

	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("item taken but no result after the pipeline latency");

	a_lat_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without an item taken one latency earlier");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (heading <= vhd_pkg::HEAD_MAX))
		else $error("heading out of range");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy rose again after reset");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int PIPE_LAT = 16;
	localparam logic [63:0] PI_FIX60 = 64'h3243F6A8885A308D;
	localparam real DEG_TO_RAD = 3.14159265358979 / 180.0;

	typedef struct {
		logic signed [vhd_pkg::COORD_W-1:0] x;
		logic signed [vhd_pkg::COORD_W-1:0] y;
		logic [vhd_pkg::HEAD_W-1:0]         heading;
	} pending_heading_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               start = 1'b0;
	logic signed [vhd_pkg::COORD_W-1:0] dx = '0;
	logic signed [vhd_pkg::COORD_W-1:0] dy = '0;
	logic                               busy;
	logic [vhd_pkg::HEAD_W-1:0]         heading;
	logic                               done;

	logic [63:0] sin_fix60 [90];
	logic [63:0] cos_fix60 [90];

	pending_heading_t pending_headings [$];
	pending_heading_t oldest;
	bit               heading_seen [360];
	int               vectors_sent = 0;
	int               headings_checked = 0;
	int               mismatches = 0;
	int               distinct_headings;

	vector_heading_degrees uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.dx      (dx),
		.dy      (dy),
		.heading (heading),
		.done    (done)
	);

	always #5 clk = ~clk;

	// Product of two Q60 values, truncated back to Q60.
	function automatic logic [63:0] fix60_mul(input logic [63:0] u, input logic [63:0] v);
		logic [127:0] p;
		p = {64'd0, u} * {64'd0, v};
		return p[123:60];
	endfunction

	// Sine and cosine of 0..89 degrees in Q60, every product truncated.
	task automatic build_trig_tables();
		logic [63:0] q;
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] s;
		logic [63:0] c;
		logic [63:0] ts;
		logic [63:0] tc;
		q = PI_FIX60 / 64'd180;
		r = PI_FIX60 % 64'd180;
		for (int k = 0; k <= 45; k++) begin
			x  = q * 64'(k) + (r * 64'(k)) / 64'd180;
			x2 = fix60_mul(x, x);
			s  = x;
			c  = 64'd1 << 60;
			ts = x;
			tc = 64'd1 << 60;
			for (int n = 1; n < 30; n++) begin
				ts = fix60_mul(ts, x2) / 64'((2 * n) * (2 * n + 1));
				tc = fix60_mul(tc, x2) / 64'((2 * n - 1) * (2 * n));
				if (n % 2 == 1) begin
					s = s - ts;
					c = c - tc;
				end else begin
					s = s + ts;
					c = c + tc;
				end
			end
			sin_fix60[k] = s;
			cos_fix60[k] = c;
		end
		// Equal legs must give exactly 45 degrees.
		sin_fix60[45] = cos_fix60[45];
		for (int k = 46; k < 90; k++) begin
			sin_fix60[k] = cos_fix60[90 - k];
			cos_fix60[k] = sin_fix60[90 - k];
		end
	endtask

	function automatic logic [vhd_pkg::COORD_W:0] magnitude_of(
			input logic signed [vhd_pkg::COORD_W-1:0] v);
		logic [vhd_pkg::COORD_W:0] w;
		w = {v[vhd_pkg::COORD_W-1], v};
		return w[vhd_pkg::COORD_W] ? -w : w;
	endfunction

	function automatic logic [vhd_pkg::HEAD_W-1:0] heading_of(
			input logic signed [vhd_pkg::COORD_W-1:0] x,
			input logic signed [vhd_pkg::COORD_W-1:0] y);
		logic [vhd_pkg::COORD_W:0]  a;
		logic [vhd_pkg::COORD_W:0]  b;
		logic                       x_neg;
		logic                       y_neg;
		logic [127:0]               lhs;
		logic [127:0]               rhs;
		logic [vhd_pkg::HEAD_W-1:0] t;
		bit                         stop;
		a     = magnitude_of(x);
		b     = magnitude_of(y);
		x_neg = x[vhd_pkg::COORD_W-1];
		y_neg = y[vhd_pkg::COORD_W-1];
		t     = '0;
		stop  = 1'b0;
		if (a == 0 && b == 0)
			return vhd_pkg::HEAD_45;
		if (b == 0)
			return x_neg ? vhd_pkg::HEAD_180 : vhd_pkg::HEAD_0;
		if (a == 0)
			return y_neg ? vhd_pkg::HEAD_270 : vhd_pkg::HEAD_90;
		// The truncated angle is the number of whole degrees k with tan(k) <= a / b.
		for (int k = 1; k < 90; k++) begin
			lhs = 128'(a) * 128'(cos_fix60[k]);
			rhs = 128'(b) * 128'(sin_fix60[k]);
			if (!stop && lhs >= rhs)
				t = t + 1'b1;
			else
				stop = 1'b1;
		end
		if (x_neg && !y_neg)
			return vhd_pkg::HEAD_90 + t;
		if (!x_neg && y_neg)
			return vhd_pkg::HEAD_270 + t;
		if (!x_neg && !y_neg)
			return vhd_pkg::HEAD_90 - t;
		return vhd_pkg::HEAD_270 - t;
	endfunction

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (pending_headings.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: heading %0d arrived with none expected", heading);
			end else begin
				oldest = pending_headings.pop_front();
				headings_checked++;
				if (heading < 360)
					heading_seen[heading] = 1'b1;
				if (heading !== oldest.heading) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: dx=%0d dy=%0d expected heading %0d, got %0d",
							oldest.x, oldest.y, oldest.heading, heading);
				end
			end
		end
	end

	task automatic send_vector(input logic signed [vhd_pkg::COORD_W-1:0] x,
			input logic signed [vhd_pkg::COORD_W-1:0] y);
		@(negedge clk);
		start <= 1'b1;
		dx    <= x;
		dy    <= y;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_headings.push_back('{x, y, heading_of(x, y)});
		vectors_sent++;
	endtask

	// Inputs are scrambled while start is low; the block must ignore them.
	task automatic idle_cycles(input int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
			dx    <= vhd_pkg::COORD_W'($urandom);
			dy    <= vhd_pkg::COORD_W'($urandom);
		end
	endtask

	task automatic wait_for_all_headings();
		@(negedge clk);
		start <= 1'b0;
		while (pending_headings.size() != 0)
			@(posedge clk);
	endtask

	// A vector whose angle lies within about one unit of a whole degree.
	task automatic pick_near_boundary(output logic signed [vhd_pkg::COORD_W-1:0] x,
			output logic signed [vhd_pkg::COORD_W-1:0] y);
		int  k;
		int  off;
		int  a;
		int  b;
		real r;
		k   = $urandom_range(1, 89);
		off = $urandom_range(0, 2) - 1;
		r   = $urandom_range(1000, 32000);
		if (k <= 45) begin
			b = $rtoi(r);
			a = $rtoi(r * $tan(k * DEG_TO_RAD) + 0.5) + off;
		end else begin
			a = $rtoi(r);
			b = $rtoi(r / $tan(k * DEG_TO_RAD) + 0.5) + off;
		end
		if (a < 1)
			a = 1;
		if (b < 1)
			b = 1;
		if (a > 32767)
			a = 32767;
		if (b > 32767)
			b = 32767;
		x = vhd_pkg::COORD_W'($urandom_range(0, 1) ? -a : a);
		y = vhd_pkg::COORD_W'($urandom_range(0, 1) ? -b : b);
	endtask

	task automatic test_axes_and_origin();
		send_vector(0, 0);
		send_vector(1, 0);
		send_vector(32767, 0);
		send_vector(-1, 0);
		send_vector(-32768, 0);
		send_vector(0, 1);
		send_vector(0, 32767);
		send_vector(0, -1);
		send_vector(0, -32768);
	endtask

	task automatic test_diagonals_and_extremes();
		send_vector(1, 1);
		send_vector(-1, 1);
		send_vector(-1, -1);
		send_vector(1, -1);
		send_vector(32767, 32767);
		send_vector(-32768, -32768);
		send_vector(-32768, 32767);
		send_vector(32767, -32768);
		send_vector(1, 32767);
		send_vector(32767, 1);
		send_vector(-32768, 1);
		send_vector(1, -32768);
		send_vector(-32768, -1);
		send_vector(-1, -32768);
	endtask

	task automatic test_random_vectors(input int count, input bit with_gaps);
		logic signed [vhd_pkg::COORD_W-1:0] x;
		logic signed [vhd_pkg::COORD_W-1:0] y;
		int                                 mode;
		for (int i = 0; i < count; i++) begin
			mode = $urandom_range(0, 3);
			if (mode <= 1) begin
				x = vhd_pkg::COORD_W'($urandom);
				y = vhd_pkg::COORD_W'($urandom);
			end else if (mode == 2) begin
				x = vhd_pkg::COORD_W'(int'($urandom_range(0, 400)) - 200);
				y = vhd_pkg::COORD_W'(int'($urandom_range(0, 400)) - 200);
			end else begin
				pick_near_boundary(x, y);
			end
			send_vector(x, y);
			if (with_gaps && $urandom_range(0, 3) == 0)
				idle_cycles($urandom_range(1, 19));
		end
	endtask

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		build_trig_tables();
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		test_axes_and_origin();
		test_diagonals_and_extremes();
		wait_for_all_headings();
		test_random_vectors(1300, 1'b1);
		wait_for_all_headings();
		test_random_vectors(200, 1'b0);

		wait_for_all_headings();
		repeat (PIPE_LAT + 4) @(posedge clk);

		distinct_headings = 0;
		foreach (heading_seen[i])
			if (heading_seen[i])
				distinct_headings++;
		$display("Sent %0d vectors: origin, axes, diagonals, full-range, small and near-degree.",
			vectors_sent);
		$display("Checked %0d headings covering %0d of 360 values; %0d mismatches, %0d missing.",
			headings_checked, distinct_headings, mismatches, pending_headings.size());
		if (mismatches == 0 && pending_headings.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: sim.f
sv/vhd_pkg.sv
sv/vhd_cell.sv
sv/vector_heading_degrees.sv
tb/testbench.sv
